>>> rtl/ebl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebl_pkg - expression byte lexer shared definitions
// Token kinds, lexer modes, the token record, character constants and the
// small classification and arithmetic helpers used by the lexer core.
// ----------------------------------------------------------------------------
package ebl_pkg;

	// lexer mode
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_PUNCT,
		MODE_DISCARD
	} mode_t;

	// token kind codes as seen on the output channel
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_NUM   = 3'd0;
	localparam kind_t KIND_IDENT = 3'd1;
	localparam kind_t KIND_PUNCT = 3'd2;
	localparam kind_t KIND_END   = 3'd3;
	localparam kind_t KIND_ERR   = 3'd4;

	// characters with a meaning of their own
	localparam logic [7:0] CH_END  = 8'h00;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_GT   = 8'h3E;

	// token queue geometry
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned PTR_BITS   = 3;
	localparam int unsigned CNT_BITS   = 4;

	// one token as it leaves the block
	typedef struct packed {
		kind_t       kind;
		logic [15:0] position;
		logic [15:0] length;
		logic [63:0] number_value;
		logic [7:0]  first_char;
		logic [7:0]  second_char;
		logic        last;
	} token_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'd48) && (c <= 8'd57);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'd97) && (c <= 8'd122);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
			((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
	endfunction

	// first half of ==, !=, <=, >=
	function automatic logic pair_first(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
	endfunction

	// acc * 10 + d as shift-and-add, saturating at all ones
	function automatic logic [63:0] sat_mac10(input logic [63:0] acc, input logic [3:0] d);
		logic [67:0] sum;
		sum = (68'(acc) << 3) + (68'(acc) << 1) + 68'(d);
		if (|sum[67:64]) begin
			return '1;
		end
		return sum[63:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/ebl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebl_if - lexer stream channels
// Character input channel and token output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ebl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

interface ebl_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] position;
	logic [15:0] length;
	logic [63:0] number_value;
	logic [7:0]  first_char;
	logic [7:0]  second_char;
	logic        last;

	modport source (output valid, output kind, output position, output length,
		output number_value, output first_char, output second_char, output last,
		input ready);
	modport sink (input valid, input kind, input position, input length,
		input number_value, input first_char, input second_char, input last,
		output ready);
endinterface
`default_nettype wire

>>> rtl/expression_byte_lexer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expression_byte_lexer_core - streaming lexer for a small expression language
// One ASCII byte in per transfer, zero ends the string; tokens out one per
// transfer with kind, offset, length, value and characters.
// ----------------------------------------------------------------------------
// The lexer takes one byte per clock. A byte is registered on acceptance,
// classified against the lexer state in the following cycle, and the zero,
// one or two tokens it causes are written into an eight-entry token queue
// whose head drives the output channel; the first token of a byte thus
// passes the input register and the queue before it is presented. Input
// is stalled only when the queue cannot guarantee room for two tokens from
// both the byte in flight and the next one, so a sink that takes one token
// per cycle sees one byte per cycle sustained. Number values saturate at
// all ones and the byte offset saturates at 2^POS_BITS-1; a zero byte emits
// the end token and rewinds the offset to zero for the next string.
module expression_byte_lexer_core #(
	parameter int unsigned POS_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	ebl_char_if.sink            chars,
	ebl_token_if.source         tokens
);
	import ebl_pkg::*;

	localparam logic [CNT_BITS:0] PAIR    = (CNT_BITS + 1)'(2);
	localparam logic [CNT_BITS:0] DEPTH_C = (CNT_BITS + 1)'(FIFO_DEPTH);

	// input register
	logic                valid_s1;
	logic [7:0]          ch_s1;

	// lexer state
	mode_t               mode_q, mode_n;
	logic [7:0]          held_q, held_n;
	logic [63:0]         acc_q, acc_n;
	logic [POS_BITS-1:0] start_q, start_n;
	logic [POS_BITS-1:0] off_q, off_n;

	// token queue
	token_t              fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS:0]   committed;

	// per-byte results
	token_t              tok_a, tok_b, push0, push1;
	logic                a_v, b_v, push0_v, push1_v, pop, accept;
	logic [POS_BITS:0]   diff, diff_pair;
	logic [32:0]         start_w, off_w, len_w, len_pair_w;

	// input handshake: leave room for two tokens from the byte in flight and the next
	assign committed   = {1'b0, count_q} + (valid_s1 ? PAIR : '0);
	assign chars.ready = (committed + PAIR) <= DEPTH_C;
	assign accept      = chars.valid & chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= chars.ch;
		end
	end

	// offsets and lengths, masked to the 16-bit output fields
	assign diff       = {1'b0, off_q} - {1'b0, start_q};
	assign diff_pair  = diff + (POS_BITS + 1)'(1);
	assign start_w    = 33'(start_q);
	assign off_w      = 33'(off_q);
	assign len_w      = 33'(diff);
	assign len_pair_w = 33'(diff_pair);

	// classify the registered byte against the pending state
	always_comb begin
		logic done;
		done    = 1'b0;
		tok_a   = '0;
		tok_b   = '0;
		a_v     = 1'b0;
		b_v     = 1'b0;
		mode_n  = mode_q;
		held_n  = held_q;
		acc_n   = acc_q;
		start_n = start_q;
		off_n   = off_q;

		// finish or extend the pending token
		case (mode_q)
			MODE_NUM: begin
				if (is_digit(ch_s1)) begin
					acc_n = sat_mac10(acc_q, 4'(ch_s1 - CH_ZERO));
					done  = 1'b1;
				end else begin
					a_v                = 1'b1;
					tok_a.kind         = KIND_NUM;
					tok_a.position     = start_w[15:0];
					tok_a.length       = len_w[15:0];
					tok_a.number_value = acc_q;
					mode_n             = MODE_IDLE;
				end
			end
			MODE_PUNCT: begin
				a_v              = 1'b1;
				tok_a.kind       = KIND_PUNCT;
				tok_a.position   = start_w[15:0];
				tok_a.first_char = held_q;
				if (ch_s1 == CH_EQ) begin
					tok_a.length      = len_pair_w[15:0];
					tok_a.second_char = ch_s1;
					done              = 1'b1;
				end else begin
					tok_a.length = len_w[15:0];
				end
				mode_n = MODE_IDLE;
				held_n = '0;
			end
			MODE_DISCARD: begin
				if (ch_s1 != CH_END) begin
					done = 1'b1;
				end else begin
					mode_n = MODE_IDLE;
				end
			end
			default: begin
			end
		endcase

		// start something new with this byte
		if (!done) begin
			tok_b.position = off_w[15:0];
			if (ch_s1 == CH_END) begin
				b_v        = 1'b1;
				tok_b.kind = KIND_END;
			end else if (is_space(ch_s1)) begin
				b_v = 1'b0;
			end else if (is_digit(ch_s1)) begin
				mode_n  = MODE_NUM;
				start_n = off_q;
				acc_n   = 64'(ch_s1 - CH_ZERO);
			end else if (is_lower(ch_s1)) begin
				b_v              = 1'b1;
				tok_b.kind       = KIND_IDENT;
				tok_b.length     = 16'd1;
				tok_b.first_char = ch_s1;
			end else if (is_punct(ch_s1)) begin
				if (pair_first(ch_s1)) begin
					mode_n  = MODE_PUNCT;
					held_n  = ch_s1;
					start_n = off_q;
				end else begin
					b_v              = 1'b1;
					tok_b.kind       = KIND_PUNCT;
					tok_b.length     = 16'd1;
					tok_b.first_char = ch_s1;
				end
			end else begin
				b_v              = 1'b1;
				tok_b.kind       = KIND_ERR;
				tok_b.length     = 16'd1;
				tok_b.first_char = ch_s1;
				mode_n           = MODE_DISCARD;
			end
		end

		// end of string rewinds everything; otherwise advance the offset
		if (ch_s1 == CH_END) begin
			mode_n  = MODE_IDLE;
			held_n  = '0;
			acc_n   = '0;
			start_n = '0;
			off_n   = '0;
		end else if (off_q != '1) begin
			off_n = off_q + POS_BITS'(1);
		end

		// pack into queue order and mark the final token of this byte
		push0_v = a_v | b_v;
		push1_v = a_v & b_v;
		push0   = a_v ? tok_a : tok_b;
		push1   = tok_b;
		push0.last = ~push1_v;
		push1.last = 1'b1;
	end

	// lexer state register, advanced once per registered byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			held_q  <= '0;
			acc_q   <= '0;
			start_q <= '0;
			off_q   <= '0;
		end else if (valid_s1) begin
			mode_q  <= mode_n;
			held_q  <= held_n;
			acc_q   <= acc_n;
			start_q <= start_n;
			off_q   <= off_n;
		end
	end

	// token queue: up to two writes and one read per cycle
	assign pop = tokens.valid & tokens.ready;

	always_ff @(posedge clk) begin
		if (valid_s1 && push0_v) begin
			fifo_q[wr_ptr_q] <= push0;
		end
		if (valid_s1 && push1_v) begin
			fifo_q[wr_ptr_q + PTR_BITS'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (valid_s1 ? PTR_BITS'(push0_v) + PTR_BITS'(push1_v) : '0);
			rd_ptr_q <= rd_ptr_q + PTR_BITS'(pop);
			count_q  <= count_q + (valid_s1 ? CNT_BITS'(push0_v) + CNT_BITS'(push1_v) : '0)
				- CNT_BITS'(pop);
		end
	end

	// output channel driven from the queue head
	assign tokens.valid        = count_q != '0;
	assign tokens.kind         = fifo_q[rd_ptr_q].kind;
	assign tokens.position     = fifo_q[rd_ptr_q].position;
	assign tokens.length       = fifo_q[rd_ptr_q].length;
	assign tokens.number_value = fifo_q[rd_ptr_q].number_value;
	assign tokens.first_char   = fifo_q[rd_ptr_q].first_char;
	assign tokens.second_char  = fifo_q[rd_ptr_q].second_char;
	assign tokens.last         = fifo_q[rd_ptr_q].last;

endmodule
`default_nettype wire

>>> verif/tb_expression_byte_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_byte_lexer_core - self-checking bench for the byte lexer
// Streams strings of bytes into the lexer and predicts every token from its
// own model of the lexer state. Each token transfer is checked field by
// field against the oldest prediction. Stimulus is a short directed set
// followed by random strings. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_expression_byte_lexer_core;
	import ebl_pkg::*;

	localparam int unsigned POS_BITS     = 16;
	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned LIMIT        = 1_500_000;
	localparam int unsigned IDLE_PCT     = 29;

	// byte classes as the lexer sees them
	typedef enum logic [2:0] {
		CC_END,
		CC_SPACE,
		CC_DIGIT,
		CC_LOWER,
		CC_PAIR,
		CC_PUNCT,
		CC_BAD
	} char_class_t;

	function automatic char_class_t char_class(input logic [7:0] c);
		if (c == CH_END)
			return CC_END;
		if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			return CC_SPACE;
		if (c >= "0" && c <= "9")
			return CC_DIGIT;
		if (c >= "a" && c <= "z")
			return CC_LOWER;
		if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT)
			return CC_PAIR;
		// printable, not a letter or digit
		if (c >= 8'h21 && c <= 8'h7E && !(c >= "A" && c <= "Z"))
			return CC_PUNCT;
		return CC_BAD;
	endfunction

	// ------------------------------------------------------------------------
	// Token predictor and checker
	// ------------------------------------------------------------------------
	class lexer_scoreboard;
		mode_t                  mode;
		logic [7:0]             held_ch;
		logic [63:0]            run_value;
		logic [POS_BITS-1:0]    run_start;
		logic [POS_BITS-1:0]    offset;
		token_t                 due_tokens[$];
		int unsigned            errors;

		function new();
			mode      = MODE_IDLE;
			held_ch   = '0;
			run_value = '0;
			run_start = '0;
			offset    = '0;
			errors    = 0;
		endfunction

		function int unsigned pending();
			return due_tokens.size();
		endfunction

		// value * 10 + digit, stuck at all ones on overflow
		function logic [63:0] times_ten_plus(input logic [63:0] value, input logic [63:0] digit);
			if (value > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
				return 64'hFFFF_FFFF_FFFF_FFFF;
			return value * 64'd10 + digit;
		endfunction

		function token_t make_token(input kind_t k, input logic [POS_BITS-1:0] pos,
				input logic [POS_BITS-1:0] len, input logic [63:0] value,
				input logic [7:0] c1, input logic [7:0] c2);
			token_t t;
			t.kind         = k;
			t.position     = 16'(pos);
			t.length       = 16'(len);
			t.number_value = value;
			t.first_char   = c1;
			t.second_char  = c2;
			t.last         = 1'b0;
			return t;
		endfunction

		// one accepted byte: advance the model, queue the tokens it causes
		function void note_byte(input logic [7:0] c);
			token_t              made[$];
			logic [POS_BITS-1:0] o;
			logic                consumed;
			char_class_t         cls;
			o        = offset;
			consumed = 1'b0;
			cls      = char_class(c);

			// finish or extend whatever is pending
			case (mode)
				MODE_NUM: begin
					if (cls == CC_DIGIT) begin
						run_value = times_ten_plus(run_value, 64'(c - CH_ZERO));
						consumed  = 1'b1;
					end else begin
						made.push_back(make_token(KIND_NUM, run_start, o - run_start,
							run_value, 8'h00, 8'h00));
						mode = MODE_IDLE;
					end
				end
				MODE_PUNCT: begin
					if (c == CH_EQ) begin
						made.push_back(make_token(KIND_PUNCT, run_start, o - run_start + 1'b1,
							64'd0, held_ch, c));
						consumed = 1'b1;
					end else begin
						made.push_back(make_token(KIND_PUNCT, run_start, o - run_start,
							64'd0, held_ch, 8'h00));
					end
					mode    = MODE_IDLE;
					held_ch = '0;
				end
				MODE_DISCARD: begin
					if (cls != CC_END)
						consumed = 1'b1;
					else
						mode = MODE_IDLE;
				end
				default: ;
			endcase

			// the byte itself
			if (!consumed) begin
				case (cls)
					CC_END:   made.push_back(make_token(KIND_END, o, '0, 64'd0, 8'h00, 8'h00));
					CC_SPACE: ;
					CC_DIGIT: begin
						mode      = MODE_NUM;
						run_start = o;
						run_value = 64'(c - CH_ZERO);
					end
					CC_LOWER: made.push_back(make_token(KIND_IDENT, o, POS_BITS'(1), 64'd0,
						c, 8'h00));
					CC_PAIR: begin
						mode      = MODE_PUNCT;
						held_ch   = c;
						run_start = o;
					end
					CC_PUNCT: made.push_back(make_token(KIND_PUNCT, o, POS_BITS'(1), 64'd0,
						c, 8'h00));
					default: begin
						made.push_back(make_token(KIND_ERR, o, POS_BITS'(1), 64'd0, c, 8'h00));
						mode = MODE_DISCARD;
					end
				endcase
			end

			// offset rewinds on the end byte, otherwise saturates
			if (cls == CC_END) begin
				mode      = MODE_IDLE;
				held_ch   = '0;
				run_value = '0;
				run_start = '0;
				offset    = '0;
			end else if (offset != '1) begin
				offset = offset + 1'b1;
			end

			if (made.size() > 0)
				made[made.size()-1].last = 1'b1;
			foreach (made[i])
				due_tokens.push_back(made[i]);
		endfunction

		function void compare_field(input string fname, input logic [63:0] want,
				input logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
				errors++;
			end
		endfunction

		function void check_token(input token_t got);
			token_t want;
			if (due_tokens.size() == 0) begin
				$display("%0t: token with none expected, expected none actual kind %0d pos %0d",
					$time, got.kind, got.position);
				errors++;
				return;
			end
			want = due_tokens.pop_front();
			compare_field("kind", 64'(want.kind), 64'(got.kind));
			compare_field("position", 64'(want.position), 64'(got.position));
			compare_field("length", 64'(want.length), 64'(got.length));
			compare_field("number_value", want.number_value, got.number_value);
			compare_field("first_char", 64'(want.first_char), 64'(got.first_char));
			compare_field("second_char", 64'(want.second_char), 64'(got.second_char));
			compare_field("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, block
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;
	logic steady;              // no idling on either side while set
	int unsigned work_items;   // bytes sent
	logic [7:0] line_bytes[$];
	lexer_scoreboard sb;
	token_t seen;

	ebl_char_if  chars_if();
	ebl_token_if tokens_if();

	expression_byte_lexer_core #(
		.POS_BITS(POS_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// token sink readiness
	initial tokens_if.ready = 1'b0;
	always @(negedge clk) begin
		tokens_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// observe both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready)
				sb.note_byte(chars_if.ch);
			if (tokens_if.valid && tokens_if.ready) begin
				seen.kind         = tokens_if.kind;
				seen.position     = tokens_if.position;
				seen.length       = tokens_if.length;
				seen.number_value = tokens_if.number_value;
				seen.first_char   = tokens_if.first_char;
				seen.second_char  = tokens_if.second_char;
				seen.last         = tokens_if.last;
				sb.check_token(seen);
			end
		end
	end

	// run-time guard
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Byte sender and string builders
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch    <= c;
		do @(posedge clk); while (!chars_if.ready);
		@(negedge clk);
		work_items++;
	endtask

	task automatic send_line();
		foreach (line_bytes[i])
			send_byte(line_bytes[i]);
		line_bytes.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endtask

	// decimal run: mostly short, sometimes around the 64-bit limit
	task automatic add_number();
		int unsigned digits;
		if ($urandom_range(7) == 0) begin
			if ($urandom_range(1)) begin
				add_text("1844674407370955161");
				line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
			end else begin
				digits = $urandom_range(24, 20);
				repeat (digits) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
			end
		end else begin
			digits = $urandom_range(6, 1);
			repeat (digits) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
		end
	endtask

	// well-formed-ish expression with random content, then the end byte
	task automatic add_expression();
		int unsigned n_tok;
		int unsigned pick;
		logic [7:0]  c;
		n_tok = $urandom_range(12, 1);
		repeat (n_tok) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				add_number();
			end else if (pick < 50) begin
				line_bytes.push_back(8'($urandom_range("z", "a")));
			end else if (pick < 62) begin
				case ($urandom_range(3))
					0: line_bytes.push_back(CH_EQ);
					1: line_bytes.push_back(CH_BANG);
					2: line_bytes.push_back(CH_LT);
					default: line_bytes.push_back(CH_GT);
				endcase
				line_bytes.push_back(CH_EQ);
			end else if (pick < 77) begin
				do c = 8'($urandom_range(126, 33));
				while (char_class(c) != CC_PUNCT && char_class(c) != CC_PAIR);
				line_bytes.push_back(c);
			end else if (pick < 85) begin
				line_bytes.push_back($urandom_range(5) == 0 ? 8'h20 : 8'($urandom_range(13, 9)));
			end else begin
				line_bytes.push_back(8'($urandom_range(255, 1)));
			end
			if ($urandom_range(99) < 30)
				line_bytes.push_back(8'h20);
		end
		line_bytes.push_back(CH_END);
	endtask

	// hold input until every predicted token has been seen
	task automatic drain();
		chars_if.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned base;
		int unsigned sel;
		int unsigned len;
		sb             = new();
		steady         = 1'b0;
		work_items     = 0;
		arst_n         = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch    = 8'h00;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: pairs, broken pairs, pending tokens flushed by the next byte
		add_text("a>=0!x=<9");
		line_bytes.push_back(8'h0D);
		add_text("~");
		line_bytes.push_back(CH_END);
		// number flushed by a held punctuator; the end byte flushes it, two tokens from one byte
		add_text("1<");
		line_bytes.push_back(CH_END);
		// invalid bytes, discarding until the end byte
		line_bytes.push_back(8'hFF);
		add_text("q");
		line_bytes.push_back(CH_END);
		add_text("7");
		line_bytes.push_back(CH_END);
		add_text("A");
		line_bytes.push_back(8'h80);
		line_bytes.push_back(8'h01);
		line_bytes.push_back(CH_END);
		line_bytes.push_back(8'h01);
		line_bytes.push_back(CH_END);
		send_line();
		drain();

		// random strings; a stretch in the middle runs without idling
		base = 0;
		while (work_items - base < RANDOM_ITEMS) begin
			steady = (work_items - base >= 600) && (work_items - base < 1000);
			sel = $urandom_range(9);
			if (sel == 0) begin
				len = $urandom_range(8, 1);
				repeat (len) line_bytes.push_back(8'($urandom_range(255)));
				line_bytes.push_back(CH_END);
			end else if (sel == 1) begin
				line_bytes.push_back(CH_END);
			end else begin
				add_expression();
			end
			send_line();
		end
		steady = 1'b0;

		// let the last tokens out, then a short grace period
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
